FILE: sv/lpc_synthesis_filter_macros.svh
// ----------------------------------------------------------------------------
// LPC synthesis filter assertion macros
// Concurrent assertion wrappers used by the filter controller RTL, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LPC_SYNTHESIS_FILTER_MACROS_SVH
`define LPC_SYNTHESIS_FILTER_MACROS_SVH
`ifndef SYNTH
`define LPCSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPCSF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LPCSF_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPCSF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: sv/lpcsf_pkg.sv
// ----------------------------------------------------------------------------
// LPC synthesis filter package
// Types, codes and helper functions shared by the filter modules.
// ----------------------------------------------------------------------------
package lpcsf_pkg;

    localparam int TAPS       = 10;
    localparam int HIST_AW    = 4;
    localparam int COEF_W     = 16;
    localparam int NCOEF      = TAPS + 1;
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0_3  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_4_7  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_8_10 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_OVF  = 3'd3;

    localparam logic [63:0] COEF_0_3_RST  = 64'd4096;
    localparam logic [63:0] COEF_4_7_RST  = 64'd0;
    localparam logic [47:0] COEF_8_10_RST = 48'd0;

    localparam logic REQ_FILTER  = 1'b0;
    localparam logic REQ_HIST_WR = 1'b1;

    typedef logic [HIST_AW-1:0] t_haddr;
    typedef logic signed [COEF_W-1:0] t_smp;
    typedef logic [NCOEF*COEF_W-1:0] t_coef_bank;

    localparam t_haddr TAP_COUNT = t_haddr'(TAPS);
    localparam t_haddr LAST_ADDR = t_haddr'(TAPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_IN,
        ST_COPY_IN_END,
        ST_MAC,
        ST_ACC,
        ST_FINISH,
        ST_COPY_OUT,
        ST_COPY_OUT_END
    } t_state;

    typedef struct packed {
        logic   en;
        t_haddr addr;
        t_smp   data;
    } t_mem_wr;

    typedef struct packed {
        logic en;
        logic first;
    } t_mul_ctl;

    typedef struct packed {
        t_smp y;
        logic ovf;
    } t_fin;

    typedef struct packed {
        t_smp sample;
        logic overflowed;
        logic aborted;
        logic last;
    } t_result;

    function automatic t_haddr hist_addr(t_haddr base, t_haddr k);
        logic [HIST_AW:0] sum;
        sum = {1'b0, base} + {1'b0, k};
        if (sum >= {1'b0, TAP_COUNT}) begin
            sum = sum - {1'b0, TAP_COUNT};
        end
        return sum[HIST_AW-1:0];
    endfunction

    function automatic t_smp coef_sel(t_coef_bank bank, t_haddr k);
        return bank[k*COEF_W +: COEF_W];
    endfunction

endpackage

FILE: sv/lpcsf_hist_mem.sv
// ----------------------------------------------------------------------------
// LPC synthesis filter history memory
// Ten-word synchronous memory with registered read and per-word valid bits;
// a word never written since reset reads as zero.
// ----------------------------------------------------------------------------
module lpcsf_hist_mem import lpcsf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mem_wr i_wr,
    input  t_haddr  i_rd_addr,
    output t_smp    o_rd_data
);

    t_smp            r_mem [TAPS];
    logic [TAPS-1:0] r_vld;
    t_smp            r_rd_data;
    logic            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: sv/lpcsf_mac.sv
// ----------------------------------------------------------------------------
// LPC synthesis filter multiply-accumulate unit
// Registered 16x16 product, 32-bit wrapping accumulator, and the overflow
// test, saturation and rounding of the accumulated sum.
// ----------------------------------------------------------------------------
module lpcsf_mac import lpcsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_ctl i_ctl,
    input  t_smp     i_op_a,
    input  t_smp     i_op_b,
    output t_fin     o_fin
);

    localparam t_smp SAT_POS = 16'sh7FFF;
    localparam t_smp SAT_NEG = 16'sh8000;
    localparam logic [ACC_W:0] ROUND_BIAS = 33'h0_0000_8000;

    logic signed [ACC_W-1:0] r_prod;
    logic                    r_prod_vld;
    logic                    r_prod_first;
    logic [ACC_W-1:0]        r_acc;

    logic [4:0]       top;
    logic             ovf;
    logic [ACC_W-1:0] scaled;
    logic [ACC_W:0]   biased;
    logic             rnd_sat;
    t_smp             y_rnd;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
        if (r_prod_vld) begin
            r_acc <= r_prod_first ? r_prod : r_acc - r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld   <= 1'b0;
            r_prod_first <= 1'b0;
        end else begin
            r_prod_vld   <= i_ctl.en;
            r_prod_first <= i_ctl.first;
        end
    end

    always_comb begin
        top     = r_acc[ACC_W-1:ACC_W-5];
        ovf     = !((&top) || (~|top));
        scaled  = {r_acc[ACC_W-5:0], 4'b0000};
        biased  = {scaled[ACC_W-1], scaled} + ROUND_BIAS;
        rnd_sat = !biased[ACC_W] && biased[ACC_W-1];
        y_rnd   = rnd_sat ? SAT_POS : t_smp'(biased[ACC_W-1:ACC_W-16]);
        o_fin.ovf = ovf;
        if (ovf) begin
            o_fin.y = r_acc[ACC_W-1] ? SAT_NEG : SAT_POS;
        end else begin
            o_fin.y = y_rnd;
        end
    end

endmodule

FILE: sv/lpcsf_ctrl.sv
// ----------------------------------------------------------------------------
// LPC synthesis filter controller
// Sequences history copies, the tap loop and write-back over the two history
// memories, and holds the result slot and the output register.
// ----------------------------------------------------------------------------
`include "lpc_synthesis_filter_macros.svh"

module lpcsf_ctrl import lpcsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  t_smp       i_sample_in,
    input  logic       i_first_in_block,
    input  logic       i_last_in_block,
    input  logic       i_commit_history,
    input  t_haddr     i_history_index,
    input  t_smp       i_history_value,
    input  t_coef_bank i_coefs,
    input  logic       i_stop_on_overflow,
    output t_mem_wr    o_cmt_wr,
    output t_haddr     o_cmt_rd_addr,
    input  t_smp       i_cmt_rd_data,
    output t_mem_wr    o_wrk_wr,
    output t_haddr     o_wrk_rd_addr,
    input  t_smp       i_wrk_rd_data,
    output t_mul_ctl   o_mul_ctl,
    output t_smp       o_op_a,
    output t_smp       o_op_b,
    input  t_fin       i_fin,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_result    o_result
);

    t_state  r_state, n_state;
    t_haddr  r_cnt, n_cnt;
    t_haddr  r_base, n_base;
    logic    r_aborted, n_aborted;
    t_smp    r_x, n_x;
    logic    r_last, n_last;
    logic    r_commit, n_commit;
    logic    r_cp_wr, n_cp_wr;
    t_haddr  r_cp_addr, n_cp_addr;
    t_result r_res, n_res;
    logic    r_res_pend;
    logic    res_set;
    logic    res_move;
    logic    out_free;
    logic    in_accept;
    t_haddr  new_base;
    logic    r_out_valid;
    t_result r_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign res_move   = r_res_pend && out_free;
    assign o_in_stall = (r_state != ST_IDLE) || (r_res_pend && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign new_base   = (r_base == '0) ? LAST_ADDR : r_base - t_haddr'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_base      <= '0;
            r_aborted   <= 1'b0;
            r_cp_wr     <= 1'b0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_base    <= n_base;
            r_aborted <= n_aborted;
            r_cp_wr   <= n_cp_wr;
            if (res_set) begin
                r_res_pend <= 1'b1;
            end else if (res_move) begin
                r_res_pend <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_res_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_last    <= n_last;
        r_commit  <= n_commit;
        r_cp_addr <= n_cp_addr;
        if (res_set) begin
            r_res <= n_res;
        end
        if (res_move) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_base        = r_base;
        n_aborted     = r_aborted;
        n_x           = r_x;
        n_last        = r_last;
        n_commit      = r_commit;
        n_cp_wr       = 1'b0;
        n_cp_addr     = r_cnt;
        n_res         = r_res;
        res_set       = 1'b0;
        o_cmt_wr      = '0;
        o_wrk_wr      = '0;
        o_cmt_rd_addr = r_cnt;
        o_wrk_rd_addr = hist_addr(r_base, r_cnt);
        o_mul_ctl     = '0;
        o_op_a        = i_wrk_rd_data;
        o_op_b        = coef_sel(i_coefs, r_cnt);

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_req_type == REQ_HIST_WR) begin
                        o_cmt_wr.en   = i_history_index < TAP_COUNT;
                        o_cmt_wr.addr = i_history_index;
                        o_cmt_wr.data = i_history_value;
                    end else begin
                        n_x      = i_sample_in;
                        n_last   = i_last_in_block;
                        n_commit = i_commit_history;
                        n_cnt    = '0;
                        if (i_first_in_block) begin
                            n_aborted = 1'b0;
                            n_base    = '0;
                            n_state   = ST_COPY_IN;
                        end else if (r_aborted) begin
                            n_res.sample     = '0;
                            n_res.overflowed = 1'b0;
                            n_res.aborted    = 1'b1;
                            n_res.last       = i_last_in_block;
                            res_set          = 1'b1;
                        end else begin
                            n_state = ST_MAC;
                        end
                    end
                end
            end
            ST_COPY_IN: begin
                n_cp_wr = 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_state = ST_COPY_IN_END;
                end else begin
                    n_cnt = r_cnt + t_haddr'(1);
                end
            end
            ST_COPY_IN_END: begin
                n_cnt   = '0;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                o_mul_ctl.en    = 1'b1;
                o_mul_ctl.first = (r_cnt == '0);
                if (r_cnt == '0) begin
                    o_op_a = r_x;
                end
                if (r_cnt == TAP_COUNT) begin
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt + t_haddr'(1);
                end
            end
            ST_ACC: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                res_set    = 1'b1;
                n_res.last = r_last;
                n_cnt      = '0;
                n_state    = ST_IDLE;
                if (i_fin.ovf && i_stop_on_overflow) begin
                    n_aborted        = 1'b1;
                    n_res.sample     = '0;
                    n_res.overflowed = 1'b1;
                    n_res.aborted    = 1'b1;
                end else begin
                    o_wrk_wr.en      = 1'b1;
                    o_wrk_wr.addr    = new_base;
                    o_wrk_wr.data    = i_fin.y;
                    n_base           = new_base;
                    n_res.sample     = i_fin.y;
                    n_res.overflowed = i_fin.ovf;
                    n_res.aborted    = 1'b0;
                    if (r_last && r_commit) begin
                        n_state = ST_COPY_OUT;
                    end
                end
            end
            ST_COPY_OUT: begin
                n_cp_wr = 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_state = ST_COPY_OUT_END;
                end else begin
                    n_cnt = r_cnt + t_haddr'(1);
                end
            end
            ST_COPY_OUT_END: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_cp_wr && (r_state == ST_COPY_IN || r_state == ST_COPY_IN_END)) begin
            o_wrk_wr.en   = 1'b1;
            o_wrk_wr.addr = r_cp_addr;
            o_wrk_wr.data = i_cmt_rd_data;
        end
        if (r_cp_wr && (r_state == ST_COPY_OUT || r_state == ST_COPY_OUT_END)) begin
            o_cmt_wr.en   = 1'b1;
            o_cmt_wr.addr = r_cp_addr;
            o_cmt_wr.data = i_wrk_rd_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `LPCSF_ASSERT(a_finish_slot_free, i_clk, i_rst_n, (r_state == ST_FINISH) |-> !r_res_pend, "result slot busy at finish")
    `LPCSF_ASSERT(a_copy_wr_follows_read, i_clk, i_rst_n, r_cp_wr |-> ($past(r_state) == ST_COPY_IN || $past(r_state) == ST_COPY_OUT), "copy write without read")
    `LPCSF_ASSERT(a_abort_keeps_history, i_clk, i_rst_n, (r_state == ST_FINISH && i_fin.ovf && i_stop_on_overflow) |=> (r_aborted && r_base == $past(r_base)), "abort moved history")
    `LPCSF_ASSERT_NEVER(a_single_mem_write, i_clk, i_rst_n, o_wrk_wr.en && o_cmt_wr.en, "both histories written together")

endmodule

FILE: sv/lpc_synthesis_filter.sv
// A sample is not accepted until the previous one is through; the shared multiply-accumulate runs over eleven taps.
// A block's first sample and a committing last sample also copy the history between the memories.
// History writes and samples of an aborted block bypass the tap loop.
// Reset is synchronous, active low: histories read as zero, registers take their reset values.
// ----------------------------------------------------------------------------
// LPC synthesis filter
// Order-10 all-pole synthesis filter with configurable Q12 coefficients,
// committed and working histories in memory, and overflow abort or saturation.
// ----------------------------------------------------------------------------
module lpc_synthesis_filter import lpcsf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic signed [15:0]    i_sample_in,
    input  logic                  i_first_in_block,
    input  logic                  i_last_in_block,
    input  logic                  i_commit_history,
    input  logic [3:0]            i_history_index,
    input  logic signed [15:0]    i_history_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_sample_out,
    output logic                  o_overflowed,
    output logic                  o_aborted,
    output logic                  o_last_out
);

    logic [63:0] r_coef_0_3;
    logic [63:0] r_coef_4_7;
    logic [47:0] r_coef_8_10;
    logic        r_stop;

    t_coef_bank coefs;
    t_mem_wr    cmt_wr;
    t_mem_wr    wrk_wr;
    t_haddr     cmt_rd_addr;
    t_haddr     wrk_rd_addr;
    t_smp       cmt_rd_data;
    t_smp       wrk_rd_data;
    t_mul_ctl   mul_ctl;
    t_smp       op_a;
    t_smp       op_b;
    t_fin       fin;
    t_result    result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_0_3  <= COEF_0_3_RST;
            r_coef_4_7  <= COEF_4_7_RST;
            r_coef_8_10 <= COEF_8_10_RST;
            r_stop      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_COEF_0_3:  r_coef_0_3  <= i_cfg_data;
                CFG_COEF_4_7:  r_coef_4_7  <= i_cfg_data;
                CFG_COEF_8_10: r_coef_8_10 <= i_cfg_data[47:0];
                CFG_STOP_OVF:  r_stop      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign coefs = {r_coef_8_10, r_coef_4_7, r_coef_0_3};

    lpcsf_hist_mem u_cmt_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmt_wr),
        .i_rd_addr (cmt_rd_addr),
        .o_rd_data (cmt_rd_data)
    );

    lpcsf_hist_mem u_wrk_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wrk_wr),
        .i_rd_addr (wrk_rd_addr),
        .o_rd_data (wrk_rd_data)
    );

    lpcsf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_fin   (fin)
    );

    lpcsf_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_sample_in        (i_sample_in),
        .i_first_in_block   (i_first_in_block),
        .i_last_in_block    (i_last_in_block),
        .i_commit_history   (i_commit_history),
        .i_history_index    (i_history_index),
        .i_history_value    (i_history_value),
        .i_coefs            (coefs),
        .i_stop_on_overflow (r_stop),
        .o_cmt_wr           (cmt_wr),
        .o_cmt_rd_addr      (cmt_rd_addr),
        .i_cmt_rd_data      (cmt_rd_data),
        .o_wrk_wr           (wrk_wr),
        .o_wrk_rd_addr      (wrk_rd_addr),
        .i_wrk_rd_data      (wrk_rd_data),
        .o_mul_ctl          (mul_ctl),
        .o_op_a             (op_a),
        .o_op_b             (op_b),
        .i_fin              (fin),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result           (result)
    );

    assign o_sample_out = result.sample;
    assign o_overflowed = result.overflowed;
    assign o_aborted    = result.aborted;
    assign o_last_out   = result.last;

endmodule
